@@ hw/rtl/saq_pkg.sv @@
// Shared types and constants of the shortest-arc quaternion block.
package saq_pkg;

  // Up to four components go through one normalizer.
  localparam int NCOMP_MAX = 4;
  localparam int NCOMP_VEC = 3;

  // Normalizer pipeline: 5 front stages, 32 root steps, 1 prep, 31 divide steps, 1 output.
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int NORM_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

  // Whole block: input reg, normalizer, products, sums, normalizer, output reg.
  localparam int TOTAL_LAT = 2 * NORM_LAT + 4;

  // Output fraction bits of the quaternion.
  localparam int OUT_FRAC_BITS = 30;

  typedef logic signed [63:0] saq_wide_t;
  typedef logic signed [31:0] saq_q30_t;

  localparam saq_wide_t ONE_Q60  = 64'sh1000_0000_0000_0000;
  localparam saq_wide_t EPS_Q60  = 64'sd1152921504607;
  localparam saq_wide_t HALF_LIM = EPS_Q60 - ONE_Q60;
  localparam saq_q30_t  ONE_Q30  = 32'sh4000_0000;
  localparam saq_q30_t  ONE_OUT  = 32'sd1 <<< OUT_FRAC_BITS;

  typedef enum logic [1:0] {
    CASE_IDENTITY  = 2'd0,
    CASE_FALLBACK  = 2'd1,
    CASE_GENERATED = 2'd2,
    CASE_ARC       = 2'd3
  } saq_case_e;

  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic signed [31:0] dst_z;
    logic signed [31:0] fallback_x;
    logic signed [31:0] fallback_y;
    logic signed [31:0] fallback_z;
  } saq_req_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    saq_case_e          case_taken;
  } saq_res_t;

endpackage

@@ hw/rtl/saq_dly.sv @@
// Fixed-length delay line for side data that travels next to a normalizer.
module saq_dly #(
  parameter int Width = 1,
  parameter int Depth = saq_pkg::NORM_LAT
) (
  input  logic             clk_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);
  import saq_pkg::*;

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
    for (int i = 1; i < Depth; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[Depth-1];

endmodule

@@ hw/rtl/saq_norm.sv @@
// Pipelined vector normalizer: scale, sum of squares, bitwise root, bitwise divide.
module saq_norm #(
  parameter int NComp = saq_pkg::NCOMP_MAX
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  saq_pkg::saq_wide_t  vec_i [NComp],
  output logic                valid_o,
  output saq_pkg::saq_q30_t   vec_o [NComp]
);
  import saq_pkg::*;

  // stage 1: sign and magnitude
  logic             v1_q;
  logic [61:0]      m1_q [NComp];
  logic [61:0]      m1_d [NComp];
  logic [NComp-1:0] n1_q;

  always_comb begin
    for (int c = 0; c < NComp; c++) begin
      m1_d[c] = vec_i[c][63] ? 62'(-vec_i[c]) : vec_i[c][61:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NComp; c++) begin
      m1_q[c] <= m1_d[c];
      n1_q[c] <= vec_i[c][63];
    end
  end

  // stage 2: leading one of the largest magnitude (same as of the OR)
  logic             v2_q, z2_q, z2_d;
  logic [61:0]      m2_q [NComp];
  logic [NComp-1:0] n2_q;
  logic [5:0]       p2_q, p2_d;
  logic [61:0]      orv;

  always_comb begin
    orv = '0;
    for (int c = 0; c < NComp; c++) begin
      orv = orv | m1_q[c];
    end
    p2_d = '0;
    for (int b = 0; b < 62; b++) begin
      if (orv[b]) begin
        p2_d = 6'(b);
      end
    end
    z2_d = (orv == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_q <= m1_q;
    n2_q <= n1_q;
    p2_q <= p2_d;
    z2_q <= z2_d;
  end

  // stage 3: bring the top bit to bit 30
  logic             v3_q, z3_q;
  logic [30:0]      m3_q [NComp];
  logic [30:0]      m3_d [NComp];
  logic [NComp-1:0] n3_q;

  always_comb begin
    for (int c = 0; c < NComp; c++) begin
      if (p2_q >= 6'd30) begin
        m3_d[c] = 31'(m2_q[c] >> (p2_q - 6'd30));
      end else begin
        m3_d[c] = 31'(m2_q[c] << (6'd30 - p2_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m3_q <= m3_d;
    n3_q <= n2_q;
    z3_q <= z2_q;
  end

  // stage 4: squares
  logic             v4_q, z4_q;
  logic [30:0]      m4_q [NComp];
  logic [61:0]      s4_q [NComp];
  logic [NComp-1:0] n4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NComp; c++) begin
      s4_q[c] <= 62'(m3_q[c]) * 62'(m3_q[c]);
    end
    m4_q <= m3_q;
    n4_q <= n3_q;
    z4_q <= z3_q;
  end

  // stage 5: sum of squares, feeds the root pipe
  logic             rt_vld_q  [SQ_STEPS+1];
  logic [63:0]      rt_rem_q  [SQ_STEPS+1];
  logic [31:0]      rt_root_q [SQ_STEPS+1];
  logic [30:0]      rt_mag_q  [SQ_STEPS+1][NComp];
  logic [NComp-1:0] rt_neg_q  [SQ_STEPS+1];
  logic             rt_zero_q [SQ_STEPS+1];
  logic [63:0]      sum5_d;

  always_comb begin
    sum5_d = '0;
    for (int c = 0; c < NComp; c++) begin
      sum5_d = sum5_d + 64'(s4_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q[0] <= 1'b0;
    end else begin
      rt_vld_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rt_rem_q[0]  <= sum5_d;
    rt_root_q[0] <= '0;
    rt_mag_q[0]  <= m4_q;
    rt_neg_q[0]  <= n4_q;
    rt_zero_q[0] <= z4_q;
  end

  // root: one result bit per stage, MSB first
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - k;
    logic [65:0] trial;
    logic        take;

    always_comb begin
      trial = ({34'd0, rt_root_q[k]} << (B + 1)) + (66'd1 << (2 * B));
      take  = ({2'b00, rt_rem_q[k]} >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rt_rem_q[k+1]  <= take ? 64'({2'b00, rt_rem_q[k]} - trial) : rt_rem_q[k];
      rt_root_q[k+1] <= take ? (rt_root_q[k] | (32'd1 << B)) : rt_root_q[k];
      rt_mag_q[k+1]  <= rt_mag_q[k];
      rt_neg_q[k+1]  <= rt_neg_q[k];
      rt_zero_q[k+1] <= rt_zero_q[k];
    end
  end

  // divide prep: dividend = mag * 2^30 + len / 2
  logic             dv_vld_q  [DIV_STEPS+1];
  logic [31:0]      dv_rem_q  [DIV_STEPS+1][NComp];
  logic [30:0]      dv_low_q  [DIV_STEPS+1][NComp];
  logic [30:0]      dv_quo_q  [DIV_STEPS+1][NComp];
  logic [31:0]      dv_len_q  [DIV_STEPS+1];
  logic [NComp-1:0] dv_neg_q  [DIV_STEPS+1];
  logic             dv_zero_q [DIV_STEPS+1];
  logic [61:0]      nd        [NComp];

  always_comb begin
    for (int c = 0; c < NComp; c++) begin
      nd[c] = {1'b0, rt_mag_q[SQ_STEPS][c], 30'd0} + {31'd0, rt_root_q[SQ_STEPS][31:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= rt_vld_q[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NComp; c++) begin
      dv_rem_q[0][c] <= {1'b0, nd[c][61:31]};
      dv_low_q[0][c] <= nd[c][30:0];
      dv_quo_q[0][c] <= '0;
    end
    dv_len_q[0]  <= rt_root_q[SQ_STEPS];
    dv_neg_q[0]  <= rt_neg_q[SQ_STEPS];
    dv_zero_q[0] <= rt_zero_q[SQ_STEPS];
  end

  // restoring divide: one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int J = DIV_STEPS - 1 - k;
    logic [32:0] r  [NComp];
    logic        ge [NComp];

    always_comb begin
      for (int c = 0; c < NComp; c++) begin
        r[c]  = {dv_rem_q[k][c], dv_low_q[k][c][J]};
        ge[c] = (r[c] >= {1'b0, dv_len_q[k]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int c = 0; c < NComp; c++) begin
        dv_rem_q[k+1][c] <= ge[c] ? 32'(r[c] - {1'b0, dv_len_q[k]}) : r[c][31:0];
        dv_quo_q[k+1][c] <= {dv_quo_q[k][c][29:0], ge[c]};
      end
      dv_low_q[k+1]  <= dv_low_q[k];
      dv_len_q[k+1]  <= dv_len_q[k];
      dv_neg_q[k+1]  <= dv_neg_q[k];
      dv_zero_q[k+1] <= dv_zero_q[k];
    end
  end

  // output: restore sign, zero vector gives zeros
  logic     vo_q;
  saq_q30_t vo_d [NComp];
  saq_q30_t vec_q [NComp];

  always_comb begin
    for (int c = 0; c < NComp; c++) begin
      if (dv_zero_q[DIV_STEPS]) begin
        vo_d[c] = '0;
      end else if (dv_neg_q[DIV_STEPS][c]) begin
        vo_d[c] = -$signed({1'b0, dv_quo_q[DIV_STEPS][c]});
      end else begin
        vo_d[c] = $signed({1'b0, dv_quo_q[DIV_STEPS][c]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vo_d;
  end

  assign valid_o = vo_q;
  assign vec_o   = vec_q;

endmodule

@@ hw/rtl/shortest_arc_quaternion.sv @@
// Top level: shortest-arc rotation quaternion between two vectors, fully pipelined.
//
//   channel   dir  handshake            payload
//   request   in   start_i, busy_o      req_i  (saq_req_t, Q16.16 vectors)
//   result    out  done_o (1-cycle)     res_o  (saq_res_t, Q2.30 quaternion)
//
// A new request is taken every clock. Two normalizers in series set the pipe depth:
// each is a 70-stage pipe (32 root steps and 31 divide steps, one bit per stage).
// busy_o stays low; the pipe always advances, so nothing is held or dropped.
// Reset clears only the valid bits; payload registers are not reset.
// done_o is a one-cycle strobe; the receiver has to take the result then.
module shortest_arc_quaternion (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  saq_pkg::saq_req_t req_i,
  output logic              done_o,
  output saq_pkg::saq_res_t res_o
);
  import saq_pkg::*;

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic [32:0] RND = (SH > 0) ? (33'd1 << ((SH > 0) ? SH - 1 : 0)) : 33'd0;

  // signed 32x32 product
  function automatic saq_wide_t smul(saq_q30_t x, saq_q30_t y);
    return saq_wide_t'(x) * saq_wide_t'(y);
  endfunction

  // Q2.30 to output format, magnitude rounded half away from zero
  function automatic saq_q30_t to_out(saq_q30_t v);
    logic [32:0] m;
    m = v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    m = (m + RND) >> SH;
    return v[31] ? saq_q30_t'(-m) : saq_q30_t'(m);
  endfunction

  assign busy_o = 1'b0;

  // ---- input register
  logic     in_vld_q;
  saq_req_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end

  // ---- half-turn axis: fallback when nonzero, else X x src or Y x src
  saq_wide_t src_w [NCOMP_VEC];
  saq_wide_t dst_w [NCOMP_VEC];
  saq_wide_t axi_w [NCOMP_VEC];
  logic      fb_nz;

  always_comb begin
    src_w[0] = saq_wide_t'(in_q.src_x);
    src_w[1] = saq_wide_t'(in_q.src_y);
    src_w[2] = saq_wide_t'(in_q.src_z);
    dst_w[0] = saq_wide_t'(in_q.dst_x);
    dst_w[1] = saq_wide_t'(in_q.dst_y);
    dst_w[2] = saq_wide_t'(in_q.dst_z);
    fb_nz = (in_q.fallback_x != '0) || (in_q.fallback_y != '0) || (in_q.fallback_z != '0);
    if (fb_nz) begin
      axi_w[0] = saq_wide_t'(in_q.fallback_x);
      axi_w[1] = saq_wide_t'(in_q.fallback_y);
      axi_w[2] = saq_wide_t'(in_q.fallback_z);
    end else if ((in_q.src_y != '0) || (in_q.src_z != '0)) begin
      axi_w[0] = '0;
      axi_w[1] = -src_w[2];
      axi_w[2] = src_w[1];
    end else begin
      axi_w[0] = src_w[2];
      axi_w[1] = '0;
      axi_w[2] = -src_w[0];
    end
  end

  // ---- three normalizers in parallel
  logic     a_vld, b_vld, x_vld;
  saq_q30_t a_n [NCOMP_VEC];
  saq_q30_t b_n [NCOMP_VEC];
  saq_q30_t x_n [NCOMP_VEC];
  logic     fb_nz_dly;

  saq_norm #(.NComp(NCOMP_VEC)) u_norm_src (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(src_w), .valid_o(a_vld), .vec_o(a_n)
  );

  saq_norm #(.NComp(NCOMP_VEC)) u_norm_dst (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(dst_w), .valid_o(b_vld), .vec_o(b_n)
  );

  saq_norm #(.NComp(NCOMP_VEC)) u_norm_axis (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(axi_w), .valid_o(x_vld), .vec_o(x_n)
  );

  saq_dly #(.Width(1), .Depth(NORM_LAT)) u_dly_fb (
    .clk_i, .data_i(fb_nz), .data_o(fb_nz_dly)
  );

  // ---- products: 3 for the dot, 6 for the cross
  logic      p_vld_q, p_fb_q;
  saq_wide_t p_q [9];
  saq_q30_t  p_ax_q [NCOMP_VEC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= a_vld & b_vld & x_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= smul(a_n[0], b_n[0]);
    p_q[1] <= smul(a_n[1], b_n[1]);
    p_q[2] <= smul(a_n[2], b_n[2]);
    p_q[3] <= smul(a_n[1], b_n[2]);
    p_q[4] <= smul(a_n[2], b_n[1]);
    p_q[5] <= smul(a_n[2], b_n[0]);
    p_q[6] <= smul(a_n[0], b_n[2]);
    p_q[7] <= smul(a_n[0], b_n[1]);
    p_q[8] <= smul(a_n[1], b_n[0]);
    p_ax_q <= x_n;
    p_fb_q <= fb_nz_dly;
  end

  // ---- dot and cross sums (Q4.60, exact)
  logic      s_vld_q, s_fb_q;
  saq_wide_t d_q;
  saq_wide_t c_q [NCOMP_VEC];
  saq_q30_t  s_ax_q [NCOMP_VEC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= p_q[0] + p_q[1] + p_q[2];
    c_q[0] <= p_q[3] - p_q[4];
    c_q[1] <= p_q[5] - p_q[6];
    c_q[2] <= p_q[7] - p_q[8];
    s_ax_q <= p_ax_q;
    s_fb_q <= p_fb_q;
  end

  // ---- classify, and normalize (1 + d, cross) for the general arc
  saq_case_e kind;
  saq_wide_t v_w [NCOMP_MAX];

  always_comb begin
    priority if (d_q >= ONE_Q60) begin
      kind = CASE_IDENTITY;
    end else if (d_q < HALF_LIM) begin
      kind = s_fb_q ? CASE_FALLBACK : CASE_GENERATED;
    end else begin
      kind = CASE_ARC;
    end
    v_w[0] = ONE_Q60 + d_q;
    v_w[1] = c_q[0];
    v_w[2] = c_q[1];
    v_w[3] = c_q[2];
  end

  logic        q_vld;
  saq_q30_t    q_n [NCOMP_MAX];
  logic [97:0] side_d, side_o;
  saq_case_e   kind_o;
  saq_q30_t    ax_o [NCOMP_VEC];

  saq_norm #(.NComp(NCOMP_MAX)) u_norm_arc (
    .clk_i, .rst_ni, .valid_i(s_vld_q), .vec_i(v_w), .valid_o(q_vld), .vec_o(q_n)
  );

  assign side_d = {kind, s_ax_q[0], s_ax_q[1], s_ax_q[2]};

  saq_dly #(.Width(98), .Depth(NORM_LAT)) u_dly_side (
    .clk_i, .data_i(side_d), .data_o(side_o)
  );

  always_comb begin
    kind_o  = saq_case_e'(side_o[97:96]);
    ax_o[0] = side_o[95:64];
    ax_o[1] = side_o[63:32];
    ax_o[2] = side_o[31:0];
  end

  // ---- select and convert to the output format
  logic     done_q;
  saq_res_t res_q, res_d;
  saq_q30_t qs [NCOMP_MAX];

  always_comb begin
    unique case (kind_o)
      CASE_IDENTITY: begin
        qs[0] = ONE_Q30;
        qs[1] = '0;
        qs[2] = '0;
        qs[3] = '0;
      end
      CASE_FALLBACK, CASE_GENERATED: begin
        qs[0] = '0;
        qs[1] = ax_o[0];
        qs[2] = ax_o[1];
        qs[3] = ax_o[2];
      end
      default: begin
        qs = q_n;
      end
    endcase
    res_d.quat_w     = to_out(qs[0]);
    res_d.quat_x     = to_out(qs[1]);
    res_d.quat_y     = to_out(qs[2]);
    res_d.quat_z     = to_out(qs[3]);
    res_d.case_taken = kind_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/saq_chk.sv @@
// Port-level checker for the shortest-arc quaternion block, with its bind.
module saq_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input saq_pkg::saq_req_t req_i,
  input logic              done_o,
  input saq_pkg::saq_res_t res_o
);
  import saq_pkg::*;

  // every result stems from a request exactly one pipe length earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, TOTAL_LAT))
    else $error("result without matching request");

  a_ident_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.case_taken == CASE_IDENTITY) |-> (res_o.quat_w == ONE_OUT))
    else $error("identity scalar wrong");

  a_ident_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.case_taken == CASE_IDENTITY)
    |-> (res_o.quat_x == '0) && (res_o.quat_y == '0) && (res_o.quat_z == '0))
    else $error("identity vector part nonzero");

  a_half_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((res_o.case_taken == CASE_FALLBACK) || (res_o.case_taken == CASE_GENERATED))
    |-> (res_o.quat_w == '0))
    else $error("half turn with nonzero scalar");

  // full request payload kept visible to the checker
  logic unused_req;
  assign unused_req = ^req_i;

endmodule

bind shortest_arc_quaternion saq_chk u_saq_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

@@ sim/tb_shortest_arc_quaternion.sv @@
// Testbench for shortest_arc_quaternion: random and directed vector pairs checked against a predictor.
module tb_shortest_arc_quaternion;
  import saq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE30 = 64'sd1 <<< 30;
  localparam longint ONE60 = 64'sd1 <<< 60;
  localparam longint EPS60 = 64'sd1152921504607;
  localparam int     DRAIN = TOTAL_LAT + 20;
  localparam int     LIMIT = 2000000;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  saq_req_t req_i;
  logic     done_o;
  saq_res_t res_o;

  shortest_arc_quaternion dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .res_o(res_o)
  );

  saq_req_t pending_q[$];   // requests still to be driven
  saq_res_t quat_q[$];      // predicted quaternions, oldest first
  int       mismatches;
  int       checked;
  int       cycles;
  int       gap_left;
  bit       quiet_tail;     // no sender idling near the end
  bit       hold_send;      // sender paused until pipe drains
  int       case_seen[4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root, bit by bit.
  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q2.30; n components (3 or 4).
  function automatic void unitize(input longint v[4], input int n, output longint u[4]);
    longint unsigned m[4];
    bit              ng[4];
    longint unsigned mx, sum, len, qq;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      u[i] = 0;
      ng[i] = v[i] < 0;
      m[i] = ng[i] ? -v[i] : v[i];
      if (i < n && m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < n; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < n; i++) m[i] <<= 1;
    end
    for (int i = 0; i < n; i++) sum += m[i] * m[i];
    len = root64(sum);
    for (int i = 0; i < n; i++) begin
      qq = ((m[i] << 30) + (len >> 1)) / len;
      u[i] = ng[i] ? -longint'(qq) : longint'(qq);
    end
  endfunction

  function automatic logic [31:0] to_fmt(longint v);
    int              sh;
    longint unsigned m;
    sh = 30 - OUT_FRAC_BITS;
    m = (v < 0) ? -v : v;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) m = -m;
    return m[31:0];
  endfunction

  function automatic saq_res_t predict_arc(saq_req_t r);
    longint   s[4], t[4], f[4], g[4], a[4], b[4], ax[4], v[4], q[4];
    longint   d;
    saq_res_t o;
    s = '{r.src_x, r.src_y, r.src_z, 0};
    t = '{r.dst_x, r.dst_y, r.dst_z, 0};
    f = '{r.fallback_x, r.fallback_y, r.fallback_z, 0};
    q = '{0, 0, 0, 0};
    unitize(s, 3, a);
    unitize(t, 3, b);
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (d >= ONE60) begin
      q[0] = ONE30;
      o.case_taken = CASE_IDENTITY;
    end else if (d < EPS60 - ONE60) begin
      if (f[0] != 0 || f[1] != 0 || f[2] != 0) begin
        unitize(f, 3, ax);
        o.case_taken = CASE_FALLBACK;
      end else begin
        if (s[1] != 0 || s[2] != 0) g = '{0, -s[2], s[1], 0};
        else g = '{s[2], 0, -s[0], 0};
        unitize(g, 3, ax);
        o.case_taken = CASE_GENERATED;
      end
      q = '{0, ax[0], ax[1], ax[2]};
    end else begin
      v[0] = ONE60 + d;
      v[1] = a[1] * b[2] - a[2] * b[1];
      v[2] = a[2] * b[0] - a[0] * b[2];
      v[3] = a[0] * b[1] - a[1] * b[0];
      unitize(v, 4, q);
      o.case_taken = CASE_ARC;
    end
    o.quat_w = to_fmt(q[0]);
    o.quat_x = to_fmt(q[1]);
    o.quat_y = to_fmt(q[2]);
    o.quat_z = to_fmt(q[3]);
    return o;
  endfunction

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 200)) - 100);
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      default: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Build a request; shapes chosen so every case branch is hit often.
  function automatic saq_req_t rnd_req();
    saq_req_t r;
    int       k;
    logic signed [31:0] sc;
    r = '{rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
          rnd_comp(), rnd_comp(), rnd_comp()};
    k = $urandom_range(0, 9);
    sc = 32'(signed'($urandom_range(1, 7)));
    if (k < 2) begin          // same direction, scaled
      r.dst_x = r.src_x >>> 3; r.dst_y = r.src_y >>> 3; r.dst_z = r.src_z >>> 3;
      if (k == 1) begin r.dst_x = r.src_x; r.dst_y = r.src_y; r.dst_z = r.src_z; end
    end else if (k < 6) begin // opposite direction
      r.src_x = r.src_x >>> 4; r.src_y = r.src_y >>> 4; r.src_z = r.src_z >>> 4;
      r.dst_x = -r.src_x * sc; r.dst_y = -r.src_y * sc; r.dst_z = -r.src_z * sc;
      if (k >= 4) r.fallback_x = 0;
      if (k >= 4) r.fallback_y = 0;
      if (k >= 4) r.fallback_z = 0;
      if (k == 5) begin r.src_y = 0; r.src_z = 0; r.dst_y = 0; r.dst_z = 0; end
    end
    return r;
  endfunction

  // Driver: changes on the falling edge, bursts of idle cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && busy_o) begin
      // request not yet taken; hold it
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start_i  <= 1'b0;
    end else if (hold_send && quat_q.size() != 0) begin
      start_i <= 1'b0;
    end else if (pending_q.size() != 0) begin
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 15) - 1;
        start_i  <= 1'b0;
      end else begin
        req_i   <= pending_q.pop_front();
        start_i <= 1'b1;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // Acceptance and checking at the rising edge.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start_i && !busy_o) quat_q.push_back(predict_arc(req_i));
    if (rst_ni && done_o) begin
      if (quat_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", res_o);
      end else begin
        saq_res_t want;
        want = quat_q.pop_front();
        checked <= checked + 1;
        case_seen[want.case_taken] <= case_seen[want.case_taken] + 1;
        if (res_o.quat_w !== want.quat_w || res_o.quat_x !== want.quat_x ||
            res_o.quat_y !== want.quat_y || res_o.quat_z !== want.quat_z ||
            res_o.case_taken !== want.case_taken) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch exp %p got %p", want, res_o);
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("FAIL shortest_arc_quaternion");
      $finish;
    end
  end

  initial begin
    saq_req_t r;
    rst_ni = 1'b0; start_i = 1'b0; req_i = '0;
    mismatches = 0; checked = 0; cycles = 0; gap_left = 0;
    quiet_tail = 0; hold_send = 0;
    case_seen = '{0, 0, 0, 0};
    // Directed: extremes, zero vectors, each case.
    pending_q.push_back('{32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0});
    pending_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0});
    pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{0, 0, 0, 32'h10000, 0, 0, 0, 0, 0});
    pending_q.push_back('{32'h10000, 0, 0, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{32'h10000, 0, 0, 32'hffff_0000, 0, 0, 0, 0, 0});
    pending_q.push_back('{32'h10000, 0, 0, 32'hffff_0000, 0, 0, 0, 0, 32'h30000});
    pending_q.push_back('{32'h10000, 0, 0, 32'hffff_0000, 0, 0,
                          32'h8000_0000, 32'h7fff_ffff, 1});
    pending_q.push_back('{0, 32'h10000, 32'h20000, 0, 32'hfff0_0000, 32'hffe0_0000, 0, 0, 0});
    pending_q.push_back('{0, 0, 32'h10000, 0, 0, 32'hffff_0000, 0, 0, 0});
    pending_q.push_back('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0});
    pending_q.push_back('{1, 0, 0, 32'hffff_ffff, 0, 0, 0, 1, 0});
    pending_q.push_back('{32'h10000, 32'h10000, 0, 32'h10000, 32'h10001, 0, 0, 0, 0});
    pending_q.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1,
                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    repeat (2) @(posedge clk_i);
    #1 rst_ni = 1'b1;
    wait (pending_q.size() == 0);
    // Pause sender until pipe is empty.
    hold_send = 1;
    for (int i = 0; i < 400; i++) begin r = rnd_req(); pending_q.push_back(r); end
    wait (quat_q.size() == 0);
    @(posedge clk_i);
    hold_send = 0;
    wait (pending_q.size() == 0);
    quiet_tail = 1;
    for (int i = 0; i < 400; i++) begin r = rnd_req(); pending_q.push_back(r); end
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (quat_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    $display("checked %0d quaternions: identity %0d, fallback %0d, generated %0d, arc %0d",
             checked, case_seen[0], case_seen[1], case_seen[2], case_seen[3]);
    if (mismatches == 0 && quat_q.size() == 0) begin
      $display("PASS shortest_arc_quaternion");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL shortest_arc_quaternion");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/saq_pkg.sv
hw/rtl/saq_dly.sv
hw/rtl/saq_norm.sv
hw/rtl/shortest_arc_quaternion.sv
hw/rtl/saq_chk.sv
sim/tb_shortest_arc_quaternion.sv
